// ----- src/xxd_pkg.sv -----
// ----------------------------------------------------------------------------
// xxd_pkg
// Shared types and constants for the XXTEA four-word block decryptor.
// ----------------------------------------------------------------------------
package xxd_pkg;

  localparam int unsigned WORDS      = 4;
  localparam int unsigned NUM_ROUNDS = 6 + 52 / WORDS;
  localparam int unsigned NUM_STAGES = NUM_ROUNDS * WORDS;
  localparam int unsigned STAGE_W    = $clog2(NUM_STAGES);
  localparam int unsigned ROUND_W    = $clog2(NUM_ROUNDS);
  localparam int unsigned WIDX_W     = $clog2(WORDS);

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  typedef logic [WORDS-1:0][31:0] blk_t;
  typedef logic [WORDS-1:0][31:0] key_t;

  localparam key_t KEY_RESET = {32'hCCDD_EEFF, 32'h8899_AABB, 32'h4455_6677, 32'h0011_2233};

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  // Running sum used in round r: starts at NUM_ROUNDS * DELTA, falls by DELTA
  function automatic logic [31:0] round_sum(input logic [ROUND_W-1:0] r);
    logic [31:0] cnt;
    cnt = 32'(NUM_ROUNDS) - 32'(r);
    return cnt * DELTA;
  endfunction

endpackage

// ----- src/xxd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// xxd_cfg_regs
// APB-style register file holding the four 32-bit key words.
// ----------------------------------------------------------------------------
module xxd_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output xxd_pkg::key_t     key
);
  import xxd_pkg::*;

  key_t     key_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_RESET;
    end else if (wr_en) begin
      key_r[idx] <= pwdata;
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY0: prdata = key_r[0];
      REG_KEY1: prdata = key_r[1];
      REG_KEY2: prdata = key_r[2];
      REG_KEY3: prdata = key_r[3];
      default:  prdata = '0;
    endcase
  end

  assign key = key_r;

endmodule

// ----- src/xxd_stage.sv -----
// ----------------------------------------------------------------------------
// xxd_stage
// One registered pipeline stage: updates a single word of the block with the
// XXTEA mix function. The stage number fixes the word, round sum and key pick.
// ----------------------------------------------------------------------------
module xxd_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [xxd_pkg::STAGE_W-1:0]  stage_idx,
  input  xxd_pkg::key_t                key,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  xxd_pkg::blk_t                up_blk,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output xxd_pkg::blk_t                dn_blk
);
  import xxd_pkg::*;

  logic                valid_r;
  blk_t                blk_r;
  blk_t                blk_nxt;
  logic [ROUND_W-1:0]  rnd;
  logic [WIDX_W-1:0]   pos;
  logic [WIDX_W-1:0]   pos_y;
  logic [WIDX_W-1:0]   pos_z;
  logic [1:0]          e_sel;
  logic [31:0]         sum;
  logic [31:0]         y;
  logic [31:0]         z;
  logic [31:0]         k;
  logic [31:0]         mix_a;
  logic [31:0]         mix_b;

  // Words are visited high to low within a round
  assign rnd   = ROUND_W'(stage_idx >> WIDX_W);
  assign pos   = WIDX_W'(WORDS - 1) - stage_idx[WIDX_W-1:0];
  assign pos_y = pos + WIDX_W'(1);
  assign pos_z = pos - WIDX_W'(1);
  assign sum   = round_sum(rnd);
  assign e_sel = sum[3:2];
  assign y     = up_blk[pos_y];
  assign z     = up_blk[pos_z];
  assign k     = key[pos[1:0] ^ e_sel];
  assign mix_a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
  assign mix_b = (sum ^ y) + (k ^ z);

  always_comb begin
    blk_nxt      = up_blk;
    blk_nxt[pos] = up_blk[pos] - (mix_a ^ mix_b);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      blk_r <= blk_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_blk   = blk_r;

endmodule

// ----- src/xxtea_block_decrypt.sv -----
// ----------------------------------------------------------------------------
// xxtea_block_decrypt
// XXTEA decryption of one 128-bit block under a 128-bit configurable key.
//
// Usage:
//   in_*   stream channel, one ciphertext block per request (4 x 32-bit words).
//   out_*  stream channel, one plaintext block per request, in order.
//   cfg_*  APB-style port, key words 0..3 at byte addresses 0x0..0xC.
//          Write the key only while no block is in flight.
// Pipeline: 19 rounds, one register stage per word update, four per round.
// Throughput: one block per cycle while out_tready is high; every stage
//   holds one block.
// Reset: all stage valid bits clear, key words return to their defaults.
// Stall: when out_tready is low the last stage holds its block; earlier
//   stages keep advancing into empty slots, and in_tready drops only once
//   every stage holds a block.
// ----------------------------------------------------------------------------
module xxtea_block_decrypt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // cipher_word0, cipher_word1, cipher_word2, cipher_word3
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // plain_word0, plain_word1, plain_word2, plain_word3
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import xxd_pkg::*;

  key_t key;
  logic vld [NUM_STAGES+1];
  logic rdy [NUM_STAGES+1];
  blk_t blk [NUM_STAGES+1];

  xxd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .key     (key)
  );

  assign vld[0]          = in_tvalid;
  assign blk[0]          = in_tdata;
  assign in_tready       = rdy[0];
  assign rdy[NUM_STAGES] = out_tready;
  assign out_tvalid      = vld[NUM_STAGES];
  assign out_tdata       = blk[NUM_STAGES];

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    xxd_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (STAGE_W'(i)),
      .key       (key),
      .up_valid  (vld[i]),
      .up_ready  (rdy[i]),
      .up_blk    (blk[i]),
      .dn_valid  (vld[i+1]),
      .dn_ready  (rdy[i+1]),
      .dn_blk    (blk[i+1])
    );
  end

endmodule

// ----- src/xxd_checker.sv -----
// ----------------------------------------------------------------------------
// xxd_checker
// Port-level checks for the block decryptor, bound to the top level.
// ----------------------------------------------------------------------------
module xxd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         cfg_pready
);

  // Nothing leaves the pipe in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // An open output drains every stage, so the input must be open as well
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while out_tready high");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Register port never waits
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

endmodule

bind xxtea_block_decrypt xxd_checker u_xxd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

// ----- tb/xxtea_block_decrypt_tb.sv -----
// ----------------------------------------------------------------------------
// xxtea_block_decrypt_tb
// Streams ciphertext blocks into the XXTEA decryptor under several keys and
// checks every plaintext block, in order, against a local decryption of the
// same block. Both stream sides idle at random; one phase holds the output
// off long enough to fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module xxtea_block_decrypt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xxd_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  key_t   key_model;
  blk_t   expected_plain[$];
  int     mismatch_count;
  int     sink_hold_cycles;
  bit     src_burst;
  bit     sink_burst;

  xxtea_block_decrypt u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decryption predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] mix_term(logic [31:0] y, logic [31:0] z,
                                           logic [31:0] sum, logic [31:0] kw);
    logic [31:0] a;
    logic [31:0] b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (kw ^ z);
    return a ^ b;
  endfunction

  function automatic blk_t xxtea_decrypt(blk_t c, key_t k);
    blk_t        v;
    logic [31:0] sum;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  e;
    v   = c;
    sum = 32'(NUM_ROUNDS) * DELTA;
    y   = v[0];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      e = sum[3:2];
      for (int p = WORDS - 1; p > 0; p--) begin
        z    = v[p-1];
        v[p] = v[p] - mix_term(y, z, sum, k[2'(p) ^ e]);
        y    = v[p];
      end
      z    = v[WORDS-1];
      v[0] = v[0] - mix_term(y, z, sum, k[e]);
      y    = v[0];
      sum  = sum - DELTA;
    end
    return v;
  endfunction

  // Mostly random words, with the extremes mixed in
  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel == 2) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic blk_t pick_block();
    blk_t b;
    for (int i = 0; i < WORDS; i++) b[i] = pick_word();
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    key_model[idx] = value;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic cfg_read_check(input reg_idx_t idx);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== key_model[idx]) begin
      $display("%0t: key register %s read: expected %h, actual %h",
               $time, idx.name(), key_model[idx], cfg_prdata);
      mismatch_count++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic load_key(input key_t k);
    cfg_write(REG_KEY0, k[0]);
    cfg_write(REG_KEY1, k[1]);
    cfg_write(REG_KEY2, k[2]);
    cfg_write(REG_KEY3, k[3]);
    cfg_read_check(REG_KEY0);
    cfg_read_check(REG_KEY1);
    cfg_read_check(REG_KEY2);
    cfg_read_check(REG_KEY3);
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_block(input blk_t c);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    do @(posedge clk); while (!in_tready);
    expected_plain.push_back(xxtea_decrypt(c, key_model));
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait out every expected block, then the pipeline depth
  task automatic drain();
    end_stream();
    while (expected_plain.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int wait_n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      wait_n = sink_burst ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (wait_n > 0 || sink_hold_cycles > 0) begin
        out_tready = 1'b0;
        repeat (wait_n) @(negedge clk);
        // long hold-off requested by the pressure test
        while (sink_hold_cycles > 0) begin
          sink_hold_cycles--;
          @(negedge clk);
        end
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : plain_check
    blk_t want;
    blk_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_plain.size() == 0) begin
        $display("%0t: unexpected plaintext block: expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_plain.pop_front();
        for (int i = 0; i < WORDS; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: plain_word%0d: expected %h, actual %h",
                     $time, i, want[i], got[i]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_key();
    key_model = KEY_RESET;
    cfg_read_check(REG_KEY0);
    cfg_read_check(REG_KEY1);
    cfg_read_check(REG_KEY2);
    cfg_read_check(REG_KEY3);
    send_block({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
    send_block({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_block({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    send_block({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF});
    send_block({32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
    send_block({32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000});
    send_block({32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
    send_block({32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001});
    send_block({32'hCCDD_EEFF, 32'h8899_AABB, 32'h4455_6677, 32'h0011_2233});
    drain();
  endtask

  task automatic test_key_extremes();
    load_key('0);
    send_block('0);
    send_block('1);
    send_block({32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001});
    send_block({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    drain();
    load_key('1);
    send_block('0);
    send_block('1);
    send_block({32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'hF0F0_F0F0});
    send_block({32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210});
    drain();
    // one hot key word at a time catches a swapped key index
    for (int i = 0; i < WORDS; i++) begin
      key_t k;
      k    = '0;
      k[i] = 32'hFFFF_FFFF;
      load_key(k);
      send_block({32'h3C3C_3C3C, 32'hC3C3_C3C3, 32'h6969_6969, 32'h9696_9696});
      drain();
    end
  endtask

  task automatic test_random_keys();
    for (int phase = 0; phase < 4; phase++) begin
      key_t k;
      for (int i = 0; i < WORDS; i++) k[i] = pick_word();
      load_key(k);
      repeat (50) send_block(pick_block());
      drain();
    end
  endtask

  task automatic test_output_stall();
    key_t k;
    for (int i = 0; i < WORDS; i++) k[i] = $urandom;
    load_key(k);
    src_burst        = 1'b1;
    sink_hold_cycles = 300;
    repeat (120) send_block(pick_block());
    src_burst = 1'b0;
    drain();
  endtask

  task automatic test_back_to_back();
    src_burst  = 1'b1;
    sink_burst = 1'b1;
    repeat (60) send_block(pick_block());
    src_burst  = 1'b0;
    sink_burst = 1'b0;
    drain();
    // restore the default key and run a few blocks under it again
    load_key(KEY_RESET);
    repeat (10) send_block(pick_block());
    drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    mismatch_count   = 0;
    sink_hold_cycles = 0;
    src_burst        = 1'b0;
    sink_burst       = 1'b0;
    key_model        = KEY_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_key();
    test_key_extremes();
    test_random_keys();
    test_output_stall();
    test_back_to_back();

    if (mismatch_count == 0 && expected_plain.size() == 0) begin
      $display("xxtea_block_decrypt_tb passed");
    end else begin
      $display("xxtea_block_decrypt_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("xxtea_block_decrypt_tb failed");
    $finish;
  end

endmodule

// ----- xxtea_block_decrypt.f -----
src/xxd_pkg.sv
src/xxd_cfg_regs.sv
src/xxd_stage.sv
src/xxtea_block_decrypt.sv
src/xxd_checker.sv
tb/xxtea_block_decrypt_tb.sv
